/* rtl/core/akt_pkg.sv */
// ----------------------------------------------------------------------------
// akt_pkg
// Shared types and codes for the aging keyed entry table.
// ----------------------------------------------------------------------------
package akt_pkg;

    localparam int PCI_W      = 9;
    localparam int FREQ_W     = 33;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 8'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd30;

    localparam logic [STATUS_W-1:0] ST_REFRESHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DISABLED  = 2'd3;

    typedef struct packed {
        logic              enabled;
        logic [PCI_W-1:0]  pci;
        logic [FREQ_W-1:0] freq;
        logic [TIME_W-1:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [PCI_W-1:0]  cell_id;
        logic [FREQ_W-1:0] frequency;
        logic [TIME_W-1:0] seen_at;
        logic [TIME_W-1:0] born_at;
    } entry_t;

endpackage

/* rtl/core/akt_in_if.sv */
// ----------------------------------------------------------------------------
// akt_in_if
// Sighting channel: valid, ready and the sighting fields.
// ----------------------------------------------------------------------------
interface akt_in_if;
    logic                       valid;
    logic                       ready;
    logic [akt_pkg::PCI_W-1:0]  pci;
    logic [akt_pkg::FREQ_W-1:0] freq;
    logic [akt_pkg::TIME_W-1:0] now_seconds;

    modport source (output valid, output pci, output freq, output now_seconds, input ready);
    modport sink   (input valid, input pci, input freq, input now_seconds, output ready);
endinterface

/* rtl/core/akt_out_if.sv */
// ----------------------------------------------------------------------------
// akt_out_if
// Result channel: valid, ready and the result fields.
// ----------------------------------------------------------------------------
interface akt_out_if;
    logic                         valid;
    logic                         ready;
    logic [akt_pkg::STATUS_W-1:0] status;
    logic [akt_pkg::SLOT_W-1:0]   slot;
    logic [akt_pkg::TIME_W-1:0]   age_seconds;
    logic [akt_pkg::COUNT_W-1:0]  expired_count;
    logic [akt_pkg::COUNT_W-1:0]  occupancy;

    modport source (output valid, output status, output slot, output age_seconds,
                    output expired_count, output occupancy, input ready);
    modport sink   (input valid, input status, input slot, input age_seconds,
                    input expired_count, input occupancy, output ready);
endinterface

/* rtl/core/akt_cfg_if.sv */
// ----------------------------------------------------------------------------
// akt_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface akt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [akt_pkg::CFG_IDX_W-1:0]  index;
    logic [akt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/aging_keyed_entry_table_top.sv */
// ----------------------------------------------------------------------------
// aging_keyed_entry_table_top
// Aging table of (pci, freq) keyed entries with timeout retirement.
// ----------------------------------------------------------------------------
// One sighting is processed at a time. A disabled sighting goes straight from
// idle to the result. For an enabled one, the match scan and the expiry scan
// each walk the entries below the high-water mark one at a time, with a request
// state and a check state per entry, through the single read port of the entry
// memory; the match scan stops at a match. A two-deep queue takes new sightings
// while one is in work, and the result register holds a finished result until
// it is taken. No clearing pass follows reset: valid marks are flip-flops cleared at once.
module aging_keyed_entry_table_top #(
    parameter int ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    akt_in_if.sink    sighting,
    akt_out_if.source result,
    akt_cfg_if.sink   cfg
);

    logic                          tracking_reg;
    logic [akt_pkg::TIMEOUT_W-1:0] timeout_reg;
    akt_pkg::queue_head_t          head;
    logic                          head_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg <= 1'b0;
            timeout_reg  <= akt_pkg::TIMEOUT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                akt_pkg::CFG_TRACKING: tracking_reg <= cfg.data[0];
                akt_pkg::CFG_TIMEOUT:  timeout_reg  <= cfg.data;
                default:               ;
            endcase
        end
    end

    akt_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .sighting         (sighting),
        .tracking_enabled (tracking_reg),
        .head             (head),
        .head_ready       (head_ready)
    );

    akt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_ready      (head_ready),
        .timeout_seconds (timeout_reg),
        .result          (result)
    );

    a_disabled_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == akt_pkg::ST_DISABLED
        |-> result.slot == '0 && result.age_seconds == '0 && result.expired_count == '0)
        else $error("disabled result carries nonzero fields");

    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == akt_pkg::ST_FULL
        |-> result.slot == '0 && result.age_seconds == '0)
        else $error("dropped result carries slot or age");

    a_insert_age: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == akt_pkg::ST_INSERTED
        |-> result.age_seconds == '0)
        else $error("new entry reports nonzero age");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid && !head_ready |=> head.valid && $stable(head.item))
        else $error("queue head changed while back end busy");

endmodule

/* rtl/core/akt_front.sv */
// ----------------------------------------------------------------------------
// akt_front
// Accepts sightings, tags them with the tracking mode and queues them.
// ----------------------------------------------------------------------------
module akt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    akt_in_if.sink               sighting,
    input  logic                 tracking_enabled,
    output akt_pkg::queue_head_t head,
    input  logic                 head_ready
);

    akt_pkg::item_t slots_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign sighting.ready = (count_reg != 2'd2);
    assign push = sighting.valid && sighting.ready;
    assign pop  = head.valid && head_ready;

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= '{enabled:     tracking_enabled,
                                       pci:         sighting.pci,
                                       freq:        sighting.freq,
                                       now_seconds: sighting.now_seconds};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/akt_back.sv */
// ----------------------------------------------------------------------------
// akt_back
// Scans the entry memory for match, free slot and expiry; drives results.
// ----------------------------------------------------------------------------
module akt_back #(
    parameter int ENTRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  akt_pkg::queue_head_t              head,
    output logic                              head_ready,
    input  logic [akt_pkg::TIMEOUT_W-1:0]     timeout_seconds,
    akt_out_if.source                         result
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MREQ  = 3'd1;
    localparam logic [2:0] S_MCHK  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_XREQ  = 3'd4;
    localparam logic [2:0] S_XCHK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    akt_pkg::entry_t mem [ENTRIES];
    akt_pkg::entry_t rd_data_reg;

    logic [2:0]                      state_reg, state_next;
    akt_pkg::item_t                  item_reg, item_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                hw_reg, hw_next;
    logic [CNT_W-1:0]                act_reg, act_next;
    logic [CNT_W-1:0]                exp_reg, exp_next;
    logic [IDX_W-1:0]                free_reg, free_next;
    logic                            free_found_reg, free_found_next;
    logic [IDX_W-1:0]                slot_reg, slot_next;
    logic [akt_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [akt_pkg::TIME_W-1:0]      first_reg, first_next;
    logic [akt_pkg::TIME_W-1:0]      age_reg, age_next;
    logic [ENTRIES-1:0]              valid_reg, valid_next;
    logic                            out_valid_reg, out_valid_next;
    logic [akt_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [akt_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [akt_pkg::TIME_W-1:0]      out_age_reg, out_age_next;
    logic [akt_pkg::COUNT_W-1:0]     out_exp_reg, out_exp_next;
    logic [akt_pkg::COUNT_W-1:0]     out_act_reg, out_act_next;
    logic                            mem_we;
    akt_pkg::entry_t                 mem_wdata;
    logic [IDX_W-1:0]                cur;
    logic [akt_pkg::TIME_W-1:0]      since_seen;

    assign cur        = idx_reg[IDX_W-1:0];
    assign since_seen = item_reg.now_seconds - rd_data_reg.seen_at;
    assign head_ready = (state_reg == S_IDLE);

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.slot          = out_slot_reg;
    assign result.age_seconds   = out_age_reg;
    assign result.expired_count = out_exp_reg;
    assign result.occupancy     = out_act_reg;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        hw_next         = hw_reg;
        act_next        = act_reg;
        exp_next        = exp_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        first_next      = first_reg;
        age_next        = age_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_age_next    = out_age_reg;
        out_exp_next    = out_exp_reg;
        out_act_next    = out_act_reg;
        mem_we          = 1'b0;
        mem_wdata       = '{cell_id:   item_reg.pci,
                            frequency: item_reg.freq,
                            seen_at:   item_reg.now_seconds,
                            born_at:   first_reg};

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    item_next       = head.item;
                    idx_next        = '0;
                    exp_next        = '0;
                    free_found_next = 1'b0;
                    slot_next       = '0;
                    age_next        = '0;
                    if (head.item.enabled)
                    begin
                        state_next = S_MREQ;
                    end
                    else
                    begin
                        status_next = akt_pkg::ST_DISABLED;
                        state_next  = S_DONE;
                    end
                end
            end
            S_MREQ:
            begin
                if (idx_reg >= hw_reg)
                begin
                    idx_next = '0;
                    if (free_found_reg)
                    begin
                        slot_next   = free_reg;
                        status_next = akt_pkg::ST_INSERTED;
                        state_next  = S_WRITE;
                    end
                    else if (hw_reg < CNT_W'(ENTRIES))
                    begin
                        slot_next   = hw_reg[IDX_W-1:0];
                        hw_next     = hw_reg + 1'b1;
                        status_next = akt_pkg::ST_INSERTED;
                        state_next  = S_WRITE;
                    end
                    else
                    begin
                        status_next = akt_pkg::ST_FULL;
                        state_next  = S_XREQ;
                    end
                end
                else
                begin
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (valid_reg[cur] && rd_data_reg.cell_id == item_reg.pci
                    && rd_data_reg.frequency == item_reg.freq)
                begin
                    slot_next   = cur;
                    status_next = akt_pkg::ST_REFRESHED;
                    first_next  = rd_data_reg.born_at;
                    state_next  = S_WRITE;
                end
                else
                begin
                    if (!valid_reg[cur] && !free_found_reg)
                    begin
                        free_next       = cur;
                        free_found_next = 1'b1;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MREQ;
                end
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (status_reg == akt_pkg::ST_INSERTED)
                begin
                    mem_wdata.born_at = item_reg.now_seconds;
                    act_next          = act_reg + 1'b1;
                    age_next          = '0;
                end
                else
                begin
                    age_next = item_reg.now_seconds - first_reg;
                end
                valid_next[slot_reg] = 1'b1;
                idx_next             = '0;
                state_next           = S_XREQ;
            end
            S_XREQ:
            begin
                state_next = (idx_reg >= hw_reg) ? S_DONE : S_XCHK;
            end
            S_XCHK:
            begin
                if (valid_reg[cur] && since_seen > {16'd0, timeout_seconds})
                begin
                    valid_next[cur] = 1'b0;
                    exp_next        = exp_reg + 1'b1;
                    act_next        = act_reg - 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_XREQ;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = akt_pkg::SLOT_W'(slot_reg);
                    out_age_next    = age_reg;
                    out_exp_next    = akt_pkg::COUNT_W'(exp_reg);
                    out_act_next    = akt_pkg::COUNT_W'(act_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[cur];
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        free_reg       <= free_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        first_reg      <= first_next;
        age_reg        <= age_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_age_reg    <= out_age_next;
        out_exp_reg    <= out_exp_next;
        out_act_reg    <= out_act_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            hw_reg         <= '0;
            act_reg        <= '0;
            exp_reg        <= '0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            hw_reg         <= hw_next;
            act_reg        <= act_next;
            exp_reg        <= exp_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule
